// File: hdl/usgfr_pkg.sv
// shared types, codes and gap table for the silence-gap frame receiver
package usgfr_pkg;

	// request codes
	typedef enum logic [1:0] {
		FUNC_BYTE    = 2'd0,
		FUNC_TICK    = 2'd1,
		FUNC_RELEASE = 2'd2,
		FUNC_READ    = 2'd3
	} func_t;

	// receive modes
	typedef enum logic [1:0] {
		MODE_READY = 2'd0,
		MODE_RECV  = 2'd1,
		MODE_ERROR = 2'd2
	} mode_t;

	localparam int BAUD_W  = 3;
	localparam int TIMER_W = 8;

	// one command transaction
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
		logic       overrun;
		logic [1:0] buffer_index;
		logic [7:0] byte_position;
	} req_t;

	// one result transaction
	typedef struct packed {
		logic       frame_done;
		logic [1:0] frame_buffer;
		logic [8:0] frame_length;
		logic [7:0] read_data;
		logic [1:0] rx_mode;
		logic       byte_dropped;
	} rsp_t;

	// silence gap in ticks per baud index, top indices share the fastest gap
	function automatic logic [TIMER_W-1:0] gap_ticks(input logic [BAUD_W-1:0] baud);
		logic [TIMER_W-1:0] g;
		unique case (baud)
			3'd0: g = 8'd42;
			3'd1: g = 8'd21;
			3'd2: g = 8'd11;
			3'd3: g = 8'd6;
			3'd4: g = 8'd4;
			default: g = 8'd2;
		endcase
		return g;
	endfunction

endpackage

// File: hdl/usgfr_store.sv
// frame byte memory, one write port and one registered read port
module usgfr_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data_q
);

	logic [7:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/usgfr_ctrl.sv
// input register, receive state update and result register
module usgfr_ctrl
	import usgfr_pkg::*;
#(
	parameter int NUM_BUFFERS = 4,
	parameter int MAX_FRAME   = 256,
	parameter int AW          = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  req_t              req,
	input  logic              cfg_valid,
	input  logic [BAUD_W-1:0] cfg_data,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [7:0]        wr_data,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	output logic              valid_s2,
	output logic              rd_hit_s2,
	output rsp_t              rsp_s2
);

	localparam int BW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int CW = $clog2(MAX_FRAME + 1);

	// input stage
	logic               valid_s1;
	req_t               req_s1;

	// receive state
	mode_t              mode_q, mode_n;
	logic [TIMER_W-1:0] timer_q, timer_n;
	logic [CW-1:0]      count_q, count_n;
	logic [BW-1:0]      active_q, active_n;
	logic [NUM_BUFFERS-1:0] busy_q, busy_n;
	logic [BAUD_W-1:0]  baud_q;

	// shared decode
	func_t              func;
	logic               is_byte, is_tick, is_release, is_read;
	logic               is_recv;
	logic [TIMER_W-1:0] timer_inc;
	logic               past_gap;
	logic               frame_full;
	logic               close;
	logic               restart;
	logic               dropped;
	logic               rd_hit;
	logic [NUM_BUFFERS-1:0] busy_mark;
	logic               idle_found;
	logic [BW-1:0]      idle_idx;
	rsp_t               rsp_n;

	assign func       = func_t'(req_s1.func);
	assign is_byte    = valid_s1 && (func == FUNC_BYTE);
	assign is_tick    = valid_s1 && (func == FUNC_TICK);
	assign is_release = valid_s1 && (func == FUNC_RELEASE);
	assign is_read    = valid_s1 && (func == FUNC_READ);
	assign is_recv    = (mode_q == MODE_RECV);
	assign timer_inc  = timer_q + 1'b1;
	assign past_gap   = timer_inc > gap_ticks(baud_q);
	assign frame_full = count_q >= CW'(MAX_FRAME);
	assign close      = is_tick && is_recv && (count_q != '0) && past_gap;
	assign restart    = is_tick && past_gap && (close || !is_recv);
	assign dropped    = is_byte && (!is_recv || frame_full);
	assign rd_hit     = (int'(req_s1.buffer_index) < NUM_BUFFERS)
	                 && (int'(req_s1.byte_position) < MAX_FRAME);

	// memory access
	assign wr_en   = is_byte && is_recv && !frame_full;
	assign wr_addr = AW'(active_q * MAX_FRAME) + AW'(count_q);
	assign wr_data = req_s1.rx_byte;
	assign rd_en   = is_read && rd_hit;
	assign rd_addr = AW'(req_s1.buffer_index * MAX_FRAME) + AW'(req_s1.byte_position);

	// buffer flags after release or close
	always_comb begin
		busy_mark = busy_q;
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			if (is_release && (int'(req_s1.buffer_index) == i)) begin
				busy_mark[i] = 1'b0;
			end
			if (close && (int'(active_q) == i)) begin
				busy_mark[i] = 1'b1;
			end
		end
	end

	// lowest idle buffer
	always_comb begin
		idle_found = 1'b0;
		idle_idx   = '0;
		for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
			if (!busy_mark[i]) begin
				idle_found = 1'b1;
				idle_idx   = BW'(i);
			end
		end
	end

	// next state
	always_comb begin
		mode_n   = mode_q;
		timer_n  = timer_q;
		count_n  = count_q;
		active_n = active_q;
		busy_n   = busy_mark;
		if (is_byte && is_recv) begin
			if (!frame_full) begin
				count_n = count_q + 1'b1;
				timer_n = '0;
			end
			if (req_s1.overrun) begin
				mode_n = MODE_ERROR;
			end
		end else if (is_tick && (!is_recv || (count_q != '0))) begin
			timer_n = timer_inc;
			if (restart) begin
				mode_n = MODE_READY;
				if (idle_found) begin
					mode_n   = MODE_RECV;
					timer_n  = '0;
					count_n  = '0;
					active_n = idle_idx;
				end
			end
		end
	end

	// result fields
	always_comb begin
		rsp_n              = '0;
		rsp_n.frame_done   = close;
		rsp_n.frame_buffer = close ? 2'(active_q) : 2'd0;
		rsp_n.frame_length = close ? 9'(count_q) : 9'd0;
		rsp_n.rx_mode      = mode_n;
		rsp_n.byte_dropped = dropped;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			rd_hit_s2 <= 1'b0;
			mode_q    <= MODE_READY;
			timer_q   <= '0;
			count_q   <= '0;
			active_q  <= '0;
			busy_q    <= '0;
			baud_q    <= BAUD_W'(1);
		end else begin
			valid_s1  <= start;
			valid_s2  <= valid_s1;
			rd_hit_s2 <= rd_en;
			mode_q    <= mode_n;
			timer_q   <= timer_n;
			count_q   <= count_n;
			active_q  <= active_n;
			busy_q    <= busy_n;
			if (cfg_valid) begin
				baud_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= req;
		end
		rsp_s2 <= rsp_n;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FRAME))
		else $error("byte count beyond frame size");

	a_active_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_RECV |-> !busy_q[active_q])
		else $error("receiving into a busy buffer");

	a_write_recv: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (mode_q == MODE_RECV) && (count_q < CW'(MAX_FRAME)))
		else $error("store write outside reception");

	a_close_mode: assert property (@(posedge clk) disable iff (!arst_n)
		close |=> valid_s2 && rsp_s2.frame_done && !rsp_s2.byte_dropped
		&& (rsp_s2.rx_mode != MODE_ERROR))
		else $error("closed frame reported wrongly");
`endif

endmodule

// File: hdl/uart_silence_gap_frame_receiver_core.sv
// top level of the silence-gap uart frame receiver
//
//   channel   signals                        direction  transaction when
//   command   start, busy, req               in         start && !busy
//   result    done, rsp                      out        done (one cycle, no stall)
//   config    cfg_valid, cfg_ready, cfg_data in         cfg_valid && cfg_ready
//
// One command per cycle; its result passes the input register, then the result register
// with the registered store read, before it is driven on rsp.
// busy stays low: every command finishes in its fixed two-stage path.
// Reset clears mode, timer, count, active buffer and busy flags; the frame
// store has no clearing pass and is used right after reset.
// Results cannot be stalled; done marks each one for a single cycle.
module uart_silence_gap_frame_receiver_core
	import usgfr_pkg::*;
#(
	parameter int NUM_BUFFERS = 4,
	parameter int MAX_FRAME   = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output rsp_t              rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [BAUD_W-1:0] cfg_data
);

	localparam int DEPTH = NUM_BUFFERS * MAX_FRAME;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data_q;
	logic          valid_s2;
	logic          rd_hit_s2;
	rsp_t          rsp_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// state update and result staging
	usgfr_ctrl #(
		.NUM_BUFFERS (NUM_BUFFERS),
		.MAX_FRAME   (MAX_FRAME),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.valid_s2  (valid_s2),
		.rd_hit_s2 (rd_hit_s2),
		.rsp_s2    (rsp_s2)
	);

	// frame byte memory
	usgfr_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data_q)
	);

	// merge read data into the result
	always_comb begin
		rsp           = rsp_s2;
		rsp.read_data = rd_hit_s2 ? rd_data_q : 8'd0;
	end

	assign done = valid_s2;

endmodule
